// ===== design/dstf_pkg.sv =====
// ----------------------------------------------------------------------------
// dstf_pkg: shared types and constants for the decimal string converter
// Character codes, parser phases, back-end states and the power-of-ten table.
// ----------------------------------------------------------------------------
package dstf_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int POW10_W = 32;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_FIN  = 2'd2
    } bk_state_t;

    // 10^k for k up to nine
    function automatic logic [POW10_W-1:0] pow10(input logic [3:0] k);
        logic [POW10_W-1:0] p;
        unique case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== design/dstf_if.sv =====
// ----------------------------------------------------------------------------
// dstf channels: character input and fixed-point result interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dstf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface dstf_result_if #(
    parameter int VALUE_W = 41
);
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

// ===== design/dstf_front.sv =====
// ----------------------------------------------------------------------------
// dstf_front: character parser
// Takes one character a beat, tracks sign, integer and fraction digits, and
// pushes the finished record on the last character.
// ----------------------------------------------------------------------------
module dstf_front #(
    parameter int INT_BITS        = 24,
    parameter int MAX_FRAC_DIGITS = 6,
    parameter int FRAC_ACC_W      = 20,
    parameter int DIG_W           = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dstf_char_if.sink             chars,
    output logic                  rec_valid,
    input  logic                  rec_ready,
    output logic                  rec_negative,
    output logic                  rec_sat,
    output logic [INT_BITS-1:0]   rec_int,
    output logic [FRAC_ACC_W-1:0] rec_frac,
    output logic [DIG_W-1:0]      rec_digits
);
    import dstf_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;
    logic [INT_BITS-1:0]   int_reg, int_next;
    logic [FRAC_ACC_W-1:0] frac_reg, frac_next;
    logic [DIG_W-1:0]      digits_reg, digits_next;

    logic                  is_digit;
    logic [3:0]            digit;
    phase_t                cur_phase;
    logic [INT_BITS+3:0]   int_ext;
    logic [INT_BITS+3:0]   int_prod;
    logic [FRAC_ACC_W+3:0] frac_ext;
    logic [FRAC_ACC_W+3:0] frac_prod;
    logic                  accept;

    assign is_digit  = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
    assign digit     = chars.char_code[3:0];
    assign cur_phase = (phase_reg == PH_START) ? PH_INT : phase_reg;

    // times ten plus digit, as two shifts and two adds
    assign int_ext   = {4'b0, int_reg};
    assign int_prod  = (int_ext << 3) + (int_ext << 1) + (INT_BITS+4)'(digit);
    assign frac_ext  = {4'b0, frac_reg};
    assign frac_prod = (frac_ext << 3) + (frac_ext << 1) + (FRAC_ACC_W+4)'(digit);

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        digits_next = digits_reg;
        priority if (phase_reg == PH_DONE)
        begin
            phase_next = PH_DONE;
        end
        else if (phase_reg == PH_START && chars.char_code == CH_PLUS)
        begin
            phase_next = PH_INT;
        end
        else if (phase_reg == PH_START && chars.char_code == CH_MINUS)
        begin
            phase_next = PH_INT;
            neg_next   = 1'b1;
        end
        else if (is_digit)
        begin
            phase_next = cur_phase;
            if (cur_phase == PH_INT)
            begin
                if (sat_reg || (int_prod[INT_BITS+3:INT_BITS] != 4'd0))
                begin
                    int_next = {INT_BITS{1'b1}};
                    sat_next = 1'b1;
                end
                else
                begin
                    int_next = int_prod[INT_BITS-1:0];
                end
            end
            else if (digits_reg < DIG_W'(MAX_FRAC_DIGITS))
            begin
                frac_next   = frac_prod[FRAC_ACC_W-1:0];
                digits_next = digits_reg + DIG_W'(1);
            end
        end
        else if (chars.char_code == CH_DOT && cur_phase == PH_INT)
        begin
            phase_next = PH_FRAC;
        end
        else
        begin
            phase_next = PH_DONE;
        end
    end

    assign chars.ready  = rec_ready;
    assign accept       = chars.valid && chars.ready;
    assign rec_valid    = chars.valid && chars.is_last;
    assign rec_negative = neg_next;
    assign rec_sat      = sat_next;
    assign rec_int      = int_next;
    assign rec_frac     = frac_next;
    assign rec_digits   = digits_next;

    // clear for the next string after the last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            int_reg    <= '0;
            frac_reg   <= '0;
            digits_reg <= '0;
        end
        else if (accept)
        begin
            if (chars.is_last)
            begin
                phase_reg  <= PH_START;
                neg_reg    <= 1'b0;
                sat_reg    <= 1'b0;
                int_reg    <= '0;
                frac_reg   <= '0;
                digits_reg <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                sat_reg    <= sat_next;
                int_reg    <= int_next;
                frac_reg   <= frac_next;
                digits_reg <= digits_next;
            end
        end
    end

endmodule

// ===== design/dstf_queue.sv =====
// ----------------------------------------------------------------------------
// dstf_queue: two-entry record queue
// Decouples the parser from the scaling back end.
// ----------------------------------------------------------------------------
module dstf_queue #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== design/dstf_back.sv =====
// ----------------------------------------------------------------------------
// dstf_back: fraction scaling and result assembly
// Divides F * 2^FRAC_BITS by 10^k one quotient bit a cycle, then joins the
// integer part, applies the sign and holds the result in an output register.
// ----------------------------------------------------------------------------
module dstf_back #(
    parameter int INT_BITS   = 24,
    parameter int FRAC_BITS  = 16,
    parameter int FRAC_ACC_W = 20,
    parameter int DIG_W      = 3,
    parameter int VALUE_W    = 41
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  logic                  rec_negative,
    input  logic                  rec_sat,
    input  logic [INT_BITS-1:0]   rec_int,
    input  logic [FRAC_ACC_W-1:0] rec_frac,
    input  logic [DIG_W-1:0]      rec_digits,
    dstf_result_if.source         results
);
    import dstf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    bk_state_t             state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FRAC_ACC_W-1:0] rem_reg, rem_next;
    logic [FRAC_ACC_W-1:0] div_reg, div_next;
    logic [FRAC_BITS-1:0]  quo_reg, quo_next;
    logic [INT_BITS-1:0]   int_reg, int_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;

    logic                  res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic                  res_ovf_reg, res_ovf_next;

    logic [FRAC_ACC_W:0]   rem_dbl;
    logic [FRAC_ACC_W:0]   rem_diff;
    logic                  rem_ge;
    logic [VALUE_W-1:0]    magnitude;
    logic                  load_out;

    assign rem_dbl   = {rem_reg, 1'b0};
    assign rem_ge    = rem_dbl >= {1'b0, div_reg};
    assign rem_diff  = rem_dbl - {1'b0, div_reg};
    assign magnitude = {1'b0, int_reg, quo_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        int_next       = int_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        rec_ready      = 1'b0;
        load_out       = 1'b0;
        res_value_next = res_value_reg;
        res_ovf_next   = res_ovf_reg;
        res_valid_next = res_valid_reg && !results.ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                rec_ready = 1'b1;
                if (rec_valid)
                begin
                    rem_next   = rec_frac;
                    div_next   = FRAC_ACC_W'(pow10(4'(rec_digits)));
                    quo_next   = '0;
                    int_next   = rec_int;
                    neg_next   = rec_negative;
                    sat_next   = rec_sat;
                    cnt_next   = CNT_W'(FRAC_BITS);
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                quo_next = {quo_reg[FRAC_BITS-2:0], rem_ge};
                rem_next = rem_ge ? rem_diff[FRAC_ACC_W-1:0] : rem_dbl[FRAC_ACC_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                // hold until the output register is free
                if (!res_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (load_out)
        begin
            res_valid_next = 1'b1;
            res_value_next = neg_reg ? (~magnitude + VALUE_W'(1)) : magnitude;
            res_ovf_next   = sat_reg;
        end
    end

    assign results.valid    = res_valid_reg;
    assign results.value    = res_value_reg;
    assign results.overflow = res_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        quo_reg       <= quo_next;
        int_reg       <= int_next;
        neg_reg       <= neg_next;
        sat_reg       <= sat_next;
        res_value_reg <= res_value_next;
        res_ovf_reg   <= res_ovf_next;
    end

endmodule

// ===== design/decimal_string_to_fixed.sv =====
// ----------------------------------------------------------------------------
// decimal_string_to_fixed: ASCII decimal string to signed fixed point
// Parses a signed decimal string one character a beat and returns one
// Q(INT_BITS.FRAC_BITS) result per string, with an integer overflow flag.
// ----------------------------------------------------------------------------
// The block takes one character per clock on the chars channel, while the
// queue has room, and marks the end of a string with is_last; on that beat the
// parsed number is handed to a two-entry queue, so the next string can start
// on the following cycle. A leading '+' or '-' sets the sign, digits build the
// integer part (held at 2^INT_BITS-1 with overflow set once it would pass
// that), a '.' starts the fraction, and the first character that does not fit
// ends parsing, the rest of the string being ignored. Only the first
// MAX_FRAC_DIGITS fraction digits count. The fraction is scaled to
// floor(F * 2^FRAC_BITS / 10^k) by a restoring divider that yields one
// quotient bit per cycle, so each string occupies the back end for a load,
// FRAC_BITS divide steps, and sign and assembly before the result is held in
// the output register. The back end takes a new string only once it has
// finished the last; long strings stream at one beat per cycle, shorter ones
// stall the input once the queue fills.
module decimal_string_to_fixed #(
    parameter int INT_BITS        = 24,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    dstf_char_if.sink     chars,
    dstf_result_if.source results
);
    import dstf_pkg::*;

    localparam int VALUE_W    = INT_BITS + FRAC_BITS + 1;
    localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int DIG_W      = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int REC_W      = 2 + INT_BITS + FRAC_ACC_W + DIG_W;

    // front to queue
    logic                  push_valid;
    logic                  push_ready;
    logic                  f_negative;
    logic                  f_sat;
    logic [INT_BITS-1:0]   f_int;
    logic [FRAC_ACC_W-1:0] f_frac;
    logic [DIG_W-1:0]      f_digits;
    logic [REC_W-1:0]      push_data;

    // queue to back
    logic                  pop_valid;
    logic                  pop_ready;
    logic [REC_W-1:0]      pop_data;
    logic                  b_negative;
    logic                  b_sat;
    logic [INT_BITS-1:0]   b_int;
    logic [FRAC_ACC_W-1:0] b_frac;
    logic [DIG_W-1:0]      b_digits;

    dstf_front #(
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .FRAC_ACC_W      (FRAC_ACC_W),
        .DIG_W           (DIG_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .chars        (chars),
        .rec_valid    (push_valid),
        .rec_ready    (push_ready),
        .rec_negative (f_negative),
        .rec_sat      (f_sat),
        .rec_int      (f_int),
        .rec_frac     (f_frac),
        .rec_digits   (f_digits)
    );

    // pack the parsed record for the queue
    assign push_data = {f_negative, f_sat, f_int, f_frac, f_digits};

    dstf_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {b_negative, b_sat, b_int, b_frac, b_digits} = pop_data;

    dstf_back #(
        .INT_BITS   (INT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .FRAC_ACC_W (FRAC_ACC_W),
        .DIG_W      (DIG_W),
        .VALUE_W    (VALUE_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (pop_valid),
        .rec_ready    (pop_ready),
        .rec_negative (b_negative),
        .rec_sat      (b_sat),
        .rec_int      (b_int),
        .rec_frac     (b_frac),
        .rec_digits   (b_digits),
        .results      (results)
    );

`ifndef SYNTHESIS
    // a last beat must leave a record waiting for the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && chars.is_last |=> pop_valid)
        else $error("record missing after last beat");

    // a positive saturated result carries an all-ones integer part
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.overflow && !results.value[VALUE_W-1]
            |-> (&results.value[VALUE_W-2:FRAC_BITS]))
        else $error("overflow flagged without saturated integer part");

    // an empty queue always accepts a push at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid |-> push_ready)
        else $error("queue full while empty");
`endif

endmodule
